FILE: rtl/multimode_state_hash_256_defines.svh
// ----------------------------------------------------------------------------
// multimode_state_hash_256 assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTIMODE_STATE_HASH_256_DEFINES_SVH
`define MULTIMODE_STATE_HASH_256_DEFINES_SVH

// Property must hold at every clock edge out of reset.
`define MSH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define MSH_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/msh256_pkg.sv
// ----------------------------------------------------------------------------
// msh256_pkg
// Types, constants and helper functions of the 256-bit multimode state hash.
// ----------------------------------------------------------------------------
`default_nettype none

package msh256_pkg;

  localparam int NUM_LANES  = 8;
  localparam int LANE_W     = 32;
  localparam int LANE_IDX_W = 3;
  localparam int MODE_W     = 3;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;
  localparam int NUM_SEEDS  = 4;

  // Key finalizer and mixing constants
  localparam logic [31:0] KEY_GOLD     = 32'h9e3779b9;
  localparam logic [31:0] FIN_MUL1     = 32'h7feb352d;
  localparam logic [31:0] FIN_MUL2     = 32'h846ca68b;
  localparam logic [31:0] MIX0_STEP    = 32'h632be59b;
  localparam logic [31:0] MIX2_MUL     = 32'h9e3779b1;
  localparam logic [31:0] MIX3_STEP    = 32'h045d9f3b;
  localparam logic [31:0] RESTART_MARK = 32'h00010001;

  // Mixing modes; the two unused codes fall back to MODE_ADD_ROT
  localparam logic [MODE_W-1:0] MODE_ROT_XOR = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MUL     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SWAP    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_XOR_KEY = 3'd3;
  localparam logic [MODE_W-1:0] MODE_GATHER  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ADD_ROT = 3'd5;

  // Register indexes, byte address 8*index
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_SEED_01 = 3'd1;
  localparam logic [2:0] REG_SEED_23 = 3'd2;
  localparam logic [2:0] REG_SEED_45 = 3'd3;
  localparam logic [2:0] REG_SEED_67 = 3'd4;

  typedef struct packed {
    logic        kind;
    logic [31:0] word;
  } in_t;

  typedef struct packed {
    logic [63:0] lanes_6_7;
    logic [63:0] lanes_4_5;
    logic [63:0] lanes_2_3;
    logic [63:0] lanes_0_1;
  } out_t;

  typedef struct packed {
    logic                  load_seed;
    logic                  load_sum;
    logic                  mul1;
    logic                  mul2;
    logic                  lane_step;
    logic [LANE_IDX_W-1:0] lane_idx;
    logic                  swap;
    logic                  out_load;
  } cmd_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] w;
    w = {v, v} << n;
    return w[63:32];
  endfunction

  // c * (mode + 1), a constant times a 4-bit factor
  function automatic logic [31:0] mode_scale(input logic [31:0] c,
                                             input logic [MODE_W-1:0] m);
    logic [3:0] f;
    f = {1'b0, m} + 4'd1;
    return c * {28'd0, f};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/msh256_ctrl.sv
// ----------------------------------------------------------------------------
// msh256_ctrl
// Sequencer: key finalizer steps, eight lane updates, mode 2 swap, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multimode_state_hash_256_defines.svh"

module msh256_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_kind,
  output logic                          in_stall,
  input  logic [msh256_pkg::MODE_W-1:0] mode,
  output logic                          out_valid,
  input  logic                          out_stall,
  output msh256_pkg::cmd_t              cmd
);
  import msh256_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_LANE,
    ST_SWAP,
    ST_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic [LANE_IDX_W-1:0] lane_idx_r, lane_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  accept;

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.load_seed = accept && !in_kind;
    cmd.load_sum  = accept && in_kind;
    cmd.mul1      = (state_r == ST_MUL1);
    cmd.mul2      = (state_r == ST_MUL2);
    cmd.lane_step = (state_r == ST_LANE);
    cmd.lane_idx  = lane_idx_r;
    cmd.swap      = (state_r == ST_SWAP);
    cmd.out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt    = state_r;
    lane_idx_nxt = lane_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_kind ? ST_MUL1 : ST_DONE;
        end
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: begin
        state_nxt    = ST_LANE;
        lane_idx_nxt = '0;
      end
      ST_LANE: begin
        lane_idx_nxt = lane_idx_r + 1'b1;
        if (lane_idx_r == LANE_IDX_W'(NUM_LANES - 1)) begin
          state_nxt = (mode == MODE_SWAP) ? ST_SWAP : ST_DONE;
        end
      end
      ST_SWAP: state_nxt = ST_DONE;
      ST_DONE: begin
        if (cmd.out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // hold the beat until taken, reload when a new result is ready
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lane_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lane_idx_r  <= lane_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `MSH_ASSERT(a_lane_start, (state_r == ST_MUL2) |=> (lane_idx_r == '0), "lane count not cleared")
  `MSH_ASSERT(a_lane_end, (state_r == ST_LANE && lane_idx_r == LANE_IDX_W'(NUM_LANES - 1)) |=> (state_r == ST_SWAP || state_r == ST_DONE), "lane pass did not end after eight lanes")
  `MSH_ASSERT(a_swap_mode, (state_r == ST_SWAP) |-> (mode == MODE_SWAP), "swap outside mode 2")
  `MSH_ASSERT_NEVER(a_no_overwrite, cmd.out_load && out_valid_r && out_stall, "result overwritten while stalled")

endmodule

`default_nettype wire

FILE: rtl/msh256_dpath.sv
// ----------------------------------------------------------------------------
// msh256_dpath
// Key finalizer, rotating lane register with one mixing unit, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module msh256_dpath (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  msh256_pkg::cmd_t                              cmd,
  input  logic [31:0]                                   in_word,
  input  logic [msh256_pkg::MODE_W-1:0]                 mode,
  input  logic [msh256_pkg::NUM_SEEDS-1:0][63:0]        seed,
  output msh256_pkg::out_t                              out_data
);
  import msh256_pkg::*;

  // lane_r[j] holds lane (i+j) mod 8 during step i, so the lane being
  // updated always sits in slot 0 and the ring turns once per step
  logic [LANE_W-1:0] lane_r   [NUM_LANES];
  logic [LANE_W-1:0] lane_nxt [NUM_LANES];
  logic [31:0]       t_r, word_r;
  out_t              out_r;

  logic [31:0]           key, mixed, lane_p, prod, fac;
  logic [LANE_IDX_W-1:0] i, p;
  logic [4:0]            i5, p5;

  assign key    = t_r ^ (t_r >> 16);
  assign i      = cmd.lane_idx;
  assign p      = word_r[LANE_IDX_W-1:0] ^ key[LANE_IDX_W-1:0];
  assign i5     = {2'b00, i};
  assign p5     = {2'b00, p};
  assign lane_p = lane_r[p];
  assign fac    = (key | 32'd1) + {28'd0, i, 1'b0};
  assign prod   = lane_r[0] * fac;

  always_comb begin
    case (mode)
      MODE_ROT_XOR:
        mixed = rotl(lane_r[0] + key + {29'd0, i} * MIX0_STEP, word_r[4:0] + i5 * 5'd3)
                ^ lane_r[3];
      MODE_MUL:
        mixed = (prod + rotl(lane_r[1], 5'd11)) ^ key;
      MODE_SWAP:
        mixed = rotl(lane_r[0] ^ key, word_r[4:0] + i5 * 5'd7) * MIX2_MUL;
      MODE_XOR_KEY:
        mixed = lane_r[0] ^ rotl(key + {29'd0, i} * MIX3_STEP, {i, 2'b00});
      MODE_GATHER:
        mixed = rotl(lane_p + key, i5 + p5);
      default:
        mixed = lane_r[0] + rotl(key ^ lane_r[1], i5 * 5'd3);
    endcase
  end

  always_comb begin
    for (int j = 0; j < NUM_LANES; j++) begin
      lane_nxt[j] = lane_r[j];
    end
    if (cmd.load_seed) begin
      for (int j = 0; j < NUM_SEEDS; j++) begin
        lane_nxt[2*j]   = seed[j][31:0];
        lane_nxt[2*j+1] = seed[j][63:32];
      end
      lane_nxt[0] = seed[0][31:0] ^ mode_scale(RESTART_MARK, mode);
    end else if (cmd.lane_step) begin
      // advance the ring, updated lane enters at the top slot
      for (int j = 0; j < NUM_LANES - 1; j++) begin
        lane_nxt[j] = lane_r[j+1];
      end
      lane_nxt[NUM_LANES-1] = mixed;
    end else if (cmd.swap) begin
      lane_nxt[0] = lane_r[3];
      lane_nxt[3] = lane_r[6];
      lane_nxt[6] = lane_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NUM_LANES; j++) begin
        lane_r[j] <= '0;
      end
    end else begin
      for (int j = 0; j < NUM_LANES; j++) begin
        lane_r[j] <= lane_nxt[j];
      end
    end
  end

  // key finalizer, one multiply per cycle
  always_ff @(posedge clk) begin
    if (cmd.load_sum) begin
      t_r    <= in_word + mode_scale(KEY_GOLD, mode);
      word_r <= in_word;
    end else if (cmd.mul1) begin
      t_r <= (t_r ^ (t_r >> 16)) * FIN_MUL1;
    end else if (cmd.mul2) begin
      t_r <= (t_r ^ (t_r >> 15)) * FIN_MUL2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.lanes_0_1 <= {lane_r[1], lane_r[0]};
      out_r.lanes_2_3 <= {lane_r[3], lane_r[2]};
      out_r.lanes_4_5 <= {lane_r[5], lane_r[4]};
      out_r.lanes_6_7 <= {lane_r[7], lane_r[6]};
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

FILE: rtl/multimode_state_hash_256.sv
// ----------------------------------------------------------------------------
// multimode_state_hash_256
// 256-bit state hash: register file, sequencer and lane datapath.
// ----------------------------------------------------------------------------
// An absorb beat runs through the accept, two finalizer multiplies, eight
// lane updates through a single shared mixing unit and the hand-off, plus
// the lane 0/3/6 swap in mode 2. A restart beat goes from the accept straight
// to the hand-off. The next beat is accepted while the previous result waits
// in the output register. Mode and seeds are written through the register
// port at byte address 8*index.
`default_nettype none

module multimode_state_hash_256 (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  msh256_pkg::in_t                       in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output msh256_pkg::out_t                      out_data,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [msh256_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [msh256_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [msh256_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                  cfg_pready
);
  import msh256_pkg::*;

  logic [MODE_W-1:0]               mode_r;
  logic [NUM_SEEDS-1:0][63:0]      seed_r;
  logic                            wr_en;
  logic [2:0]                      reg_idx;
  cmd_t                            cmd;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      seed_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:    mode_r    <= cfg_pwdata[MODE_W-1:0];
        REG_SEED_01: seed_r[0] <= cfg_pwdata;
        REG_SEED_23: seed_r[1] <= cfg_pwdata;
        REG_SEED_45: seed_r[2] <= cfg_pwdata;
        REG_SEED_67: seed_r[3] <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:    cfg_prdata = {{(CFG_DATA_W - MODE_W){1'b0}}, mode_r};
      REG_SEED_01: cfg_prdata = seed_r[0];
      REG_SEED_23: cfg_prdata = seed_r[1];
      REG_SEED_45: cfg_prdata = seed_r[2];
      REG_SEED_67: cfg_prdata = seed_r[3];
      default:     cfg_prdata = '0;
    endcase
  end

  msh256_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .in_stall  (in_stall),
    .mode      (mode_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  msh256_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_data.word),
    .mode     (mode_r),
    .seed     (seed_r),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
